// ===== rtl/chg_pkg.sv =====
// Package with the shared types, codes and constant tables of the change dispenser.
package chg_pkg;

    localparam int NUM_DENOMS = 7;
    localparam int AMOUNT_W   = 20;
    localparam int COUNT_W    = 16;
    localparam int INDEX_W    = 3;
    localparam int DENOM_W    = 7;
    localparam int RECIP_W    = 21;
    localparam int RECIP_SH   = 20;
    localparam int STEP_W     = 5;

    localparam logic [STEP_W-1:0] STEP_IDLE    = 5'd0;
    localparam logic [STEP_W-1:0] STEP_COMMIT  = 5'd15;
    localparam logic [STEP_W-1:0] STEP_RESTOCK = 5'd16;

    localparam logic REQ_RESTOCK = 1'b0;
    localparam logic REQ_PAY     = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [INDEX_W-1:0]  coin_index;
        logic [COUNT_W-1:0]  coin_count;
        logic [AMOUNT_W-1:0] amount;
    } t_req;

    typedef struct packed {
        logic                accepted;
        logic [AMOUNT_W-1:0] remainder;
    } t_res;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_EST,
        OP_UPD,
        OP_COMMIT,
        OP_RESTOCK
    } t_op;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_JUMP,
        COND_START
    } t_cond;

    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] denom;
        t_cond              cond;
        logic [STEP_W-1:0]  target;
    } t_ctrl;

    // Coin value for each denomination index.
    function automatic logic [DENOM_W-1:0] denom_value(input logic [INDEX_W-1:0] idx);
        logic [DENOM_W-1:0] v;
        v = 7'd1;
        unique case (idx)
            3'd0:    v = 7'd1;
            3'd1:    v = 7'd2;
            3'd2:    v = 7'd5;
            3'd3:    v = 7'd10;
            3'd4:    v = 7'd20;
            3'd5:    v = 7'd50;
            3'd6:    v = 7'd100;
            default: v = 7'd1;
        endcase
        return v;
    endfunction

    // floor(2^20 / value): the quotient estimate is exact or one short.
    function automatic logic [RECIP_W-1:0] denom_recip(input logic [INDEX_W-1:0] idx);
        logic [RECIP_W-1:0] r;
        r = 21'd1048576;
        unique case (idx)
            3'd0:    r = 21'd1048576;
            3'd1:    r = 21'd524288;
            3'd2:    r = 21'd209715;
            3'd3:    r = 21'd104857;
            3'd4:    r = 21'd52428;
            3'd5:    r = 21'd20971;
            3'd6:    r = 21'd10485;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

    // Microcode program: an estimate and an update step per coin, largest coin first.
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '{op: OP_IDLE, denom: 3'd0, cond: COND_JUMP, target: STEP_IDLE};
        unique case (step)
            5'd0:    c = '{op: OP_IDLE,    denom: 3'd0, cond: COND_START, target: STEP_RESTOCK};
            5'd1:    c = '{op: OP_EST,     denom: 3'd6, cond: COND_NEXT,  target: STEP_IDLE};
            5'd2:    c = '{op: OP_UPD,     denom: 3'd6, cond: COND_NEXT,  target: STEP_IDLE};
            5'd3:    c = '{op: OP_EST,     denom: 3'd5, cond: COND_NEXT,  target: STEP_IDLE};
            5'd4:    c = '{op: OP_UPD,     denom: 3'd5, cond: COND_NEXT,  target: STEP_IDLE};
            5'd5:    c = '{op: OP_EST,     denom: 3'd4, cond: COND_NEXT,  target: STEP_IDLE};
            5'd6:    c = '{op: OP_UPD,     denom: 3'd4, cond: COND_NEXT,  target: STEP_IDLE};
            5'd7:    c = '{op: OP_EST,     denom: 3'd3, cond: COND_NEXT,  target: STEP_IDLE};
            5'd8:    c = '{op: OP_UPD,     denom: 3'd3, cond: COND_NEXT,  target: STEP_IDLE};
            5'd9:    c = '{op: OP_EST,     denom: 3'd2, cond: COND_NEXT,  target: STEP_IDLE};
            5'd10:   c = '{op: OP_UPD,     denom: 3'd2, cond: COND_NEXT,  target: STEP_IDLE};
            5'd11:   c = '{op: OP_EST,     denom: 3'd1, cond: COND_NEXT,  target: STEP_IDLE};
            5'd12:   c = '{op: OP_UPD,     denom: 3'd1, cond: COND_NEXT,  target: STEP_IDLE};
            5'd13:   c = '{op: OP_EST,     denom: 3'd0, cond: COND_NEXT,  target: STEP_IDLE};
            5'd14:   c = '{op: OP_UPD,     denom: 3'd0, cond: COND_NEXT,  target: STEP_IDLE};
            5'd15:   c = '{op: OP_COMMIT,  denom: 3'd0, cond: COND_JUMP,  target: STEP_IDLE};
            5'd16:   c = '{op: OP_RESTOCK, denom: 3'd0, cond: COND_JUMP,  target: STEP_IDLE};
            default: c = '{op: OP_IDLE,    denom: 3'd0, cond: COND_JUMP,  target: STEP_IDLE};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/greedy_change_dispenser.sv =====
// Top level of the greedy change dispenser with limited coin stock.
// Pay-out word: estimate and update steps, then commit; o_done is registered from the commit step.
// Restock word: a restock step, with o_done registered from it. A new word may start while o_done shows.
// The pay-out length is set by the microcode: two steps per coin kind plus a commit step.
// Synchronous active-low reset empties the coin stock and returns the sequencer to idle.
// Each result is shown for one cycle on o_result with o_done; the receiver cannot stall.
module greedy_change_dispenser
    import chg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_result
);

    // Sequencer: a step counter addresses the microcode table. Each control word
    // names a datapath operation, the coin kind it works on and how to go on.
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;

    // Datapath registers. r_left is the unpaid amount, r_qest the quotient
    // estimate of the current coin, r_trial the counts that a commit would store.
    t_req                r_req;
    logic [AMOUNT_W-1:0] r_left;
    logic [AMOUNT_W-1:0] r_qest;
    logic [COUNT_W-1:0]  r_stock [NUM_DENOMS];
    logic [COUNT_W-1:0]  r_trial [NUM_DENOMS];
    logic                r_done;
    t_res                r_result;

    logic                accept;
    logic [DENOM_W-1:0]  dval;
    logic [COUNT_W-1:0]  have;
    logic [40:0]         est_prod;
    logic [26:0]         prod_q;
    logic [22:0]         prod_have;
    logic [AMOUNT_W-1:0] raw_rem;
    logic                fix;
    logic [AMOUNT_W-1:0] fixed_rem;
    logic [AMOUNT_W-1:0] fixed_q;
    logic                all_fit;
    logic [COUNT_W-1:0]  take;
    logic [AMOUNT_W-1:0] left_new;

    assign ctrl   = ucode(r_step);
    assign busy   = (r_step != STEP_IDLE);
    assign accept = start && !busy;

    // Next step of the program.
    always_comb begin
        n_step = r_step;
        unique case (ctrl.cond)
            COND_NEXT: begin
                n_step = r_step + STEP_W'(1);
            end
            COND_JUMP: begin
                n_step = ctrl.target;
            end
            COND_START: begin
                if (start) begin
                    n_step = (i_req.req_type == REQ_RESTOCK) ? ctrl.target
                                                             : r_step + STEP_W'(1);
                end
            end
            default: begin
                n_step = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Division by the coin value is a multiply by its scaled reciprocal. The
    // estimate is never too large and at most one short, so one compare and
    // subtract in the update step fixes both quotient and remainder.
    assign dval     = denom_value(ctrl.denom);
    assign have     = r_stock[ctrl.denom];
    assign est_prod = r_left * denom_recip(ctrl.denom);

    assign prod_q    = r_qest * dval;
    assign raw_rem   = r_left - prod_q[AMOUNT_W-1:0];
    assign fix       = (raw_rem >= AMOUNT_W'(dval));
    assign fixed_rem = fix ? raw_rem - AMOUNT_W'(dval) : raw_rem;
    assign fixed_q   = r_qest + AMOUNT_W'(fix);

    // If the whole stock of this coin fits into the unpaid amount it is all
    // taken; otherwise the quotient is below the stock and the remainder is left.
    assign prod_have = have * dval;
    assign all_fit   = (prod_have <= 23'(r_left));
    assign take      = all_fit ? have : fixed_q[COUNT_W-1:0];
    assign left_new  = all_fit ? r_left - prod_have[AMOUNT_W-1:0] : fixed_rem;

    // Coin stock: cleared by reset, written by a restock or a successful commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_DENOMS; k++) begin
                r_stock[k] <= '0;
            end
        end else begin
            if (ctrl.op == OP_RESTOCK && r_req.coin_index < INDEX_W'(NUM_DENOMS)) begin
                r_stock[r_req.coin_index] <= r_req.coin_count;
            end else if (ctrl.op == OP_COMMIT && r_left == '0) begin
                for (int k = 0; k < NUM_DENOMS; k++) begin
                    r_stock[k] <= r_trial[k];
                end
            end
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req;
            r_left <= i_req.amount;
        end
        unique case (ctrl.op)
            OP_EST: begin
                r_qest <= est_prod[AMOUNT_W+RECIP_SH-1:RECIP_SH];
            end
            OP_UPD: begin
                r_left               <= left_new;
                r_trial[ctrl.denom]  <= have - take;
            end
            OP_COMMIT: begin
                r_result.accepted  <= (r_left == '0);
                r_result.remainder <= r_left;
            end
            OP_RESTOCK: begin
                r_result.accepted  <= (r_req.coin_index < INDEX_W'(NUM_DENOMS));
                r_result.remainder <= '0;
            end
            default: begin
            end
        endcase
    end

    // Result strobe: registered, high in the cycle after the final step of each word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (ctrl.op == OP_COMMIT) || (ctrl.op == OP_RESTOCK);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/chg_checker.sv =====
// Port-level checker for the change dispenser and its bind to the top level.
module chg_checker
    import chg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_res o_result
);

    // An accepted word keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a word was started");

    // A result comes exactly when the block returns to idle.
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("block went idle without a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    // An accepted payout leaves nothing unpaid.
    a_accept_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.accepted) |-> (o_result.remainder == '0))
        else $error("accepted result with a nonzero remainder");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!busy && !o_done))
        else $error("block active right after reset");

endmodule

bind greedy_change_dispenser chg_checker u_chg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== test/tb_greedy_change_dispenser.sv =====
// Self-checking testbench for the greedy change dispenser: directed words, then random traffic.
`timescale 1ns / 100ps

module tb_greedy_change_dispenser;
    import chg_pkg::*;

    // Coin indexes as the restock word names them, plus the one index that names no coin.
    localparam logic [INDEX_W-1:0] COIN_1         = 3'd0;
    localparam logic [INDEX_W-1:0] COIN_2         = 3'd1;
    localparam logic [INDEX_W-1:0] COIN_5         = 3'd2;
    localparam logic [INDEX_W-1:0] COIN_10        = 3'd3;
    localparam logic [INDEX_W-1:0] COIN_20        = 3'd4;
    localparam logic [INDEX_W-1:0] COIN_50        = 3'd5;
    localparam logic [INDEX_W-1:0] COIN_100       = 3'd6;
    localparam logic [INDEX_W-1:0] BAD_COIN_INDEX = 3'd7;

    localparam logic [COUNT_W-1:0]  MAX_COUNT  = 16'hFFFF;
    localparam logic [AMOUNT_W-1:0] MAX_AMOUNT = 20'hFFFFF;

    localparam int unsigned COIN_VALUE [NUM_DENOMS] = '{1, 2, 5, 10, 20, 50, 100};

    // Wait after the last expected result, so that any work still in flight settles.
    localparam int DRAIN_CYCLES    = 24;
    localparam int MAX_GAP         = 20;
    localparam int WORDS_PER_PHASE = 317;
    localparam int REPORT_LIMIT    = 10;

    // One row of the directed script. When pinned is set, the expected result is typed
    // into the row; otherwise the shadow model supplies it.
    typedef struct packed {
        t_req word_in;
        logic pinned;
        t_res res;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_res o_result;

    // Travels alongside i_req so that the monitor knows whether a typed result applies.
    logic pin_valid = 1'b0;
    t_res pin_res   = '0;

    logic [COUNT_W-1:0] shadow_stock [NUM_DENOMS];
    t_res expected_results [$];
    t_row directed_rows [$];

    int failures      = 0;
    int restock_words = 0;
    int bad_index     = 0;
    int payout_words  = 0;
    int paid_exactly  = 0;
    int pay_stopped   = 0;

    greedy_change_dispenser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow model of the coin stock. A restock word overwrites one count. A pay-out word
    // walks from the largest coin down, taking as many coins as fit into what is still
    // owed but never more than are in stock; the trial counts are kept only if nothing
    // is left to pay.
    function automatic t_res dispense_change(input t_req w);
        t_res               r;
        int unsigned        owed;
        int unsigned        fit;
        int unsigned        take;
        int                 k;
        logic [COUNT_W-1:0] trial [NUM_DENOMS];
        r = '0;
        if (w.req_type == REQ_RESTOCK) begin
            // An index past the last coin changes nothing and is refused.
            if (w.coin_index < NUM_DENOMS) begin
                shadow_stock[w.coin_index] = w.coin_count;
                r.accepted = 1'b1;
            end
            return r;
        end
        owed = w.amount;
        for (k = NUM_DENOMS - 1; k >= 0; k--) begin
            fit  = owed / COIN_VALUE[k];
            take = (fit < shadow_stock[k]) ? fit : shadow_stock[k];
            owed = owed - take * COIN_VALUE[k];
            trial[k] = shadow_stock[k] - COUNT_W'(take);
        end
        if (owed == 0) begin
            for (k = 0; k < NUM_DENOMS; k++) begin
                shadow_stock[k] = trial[k];
            end
            r.accepted = 1'b1;
        end
        r.remainder = AMOUNT_W'(owed);
        return r;
    endfunction

    function automatic t_row row(input logic rt, input logic [INDEX_W-1:0] idx,
                                 input logic [COUNT_W-1:0] cnt,
                                 input logic [AMOUNT_W-1:0] amt,
                                 input logic pinned, input logic acc,
                                 input logic [AMOUNT_W-1:0] rem);
        t_row r;
        r.word_in.req_type   = rt;
        r.word_in.coin_index = idx;
        r.word_in.coin_count = cnt;
        r.word_in.amount     = amt;
        r.pinned             = pinned;
        r.res.accepted       = acc;
        r.res.remainder      = rem;
        return r;
    endfunction

    // Appends one row to the end of the directed script.
    function automatic void add_row(input t_row r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Random words lean toward what exercises the greedy pass: small restock counts
    // and small amounts, so that pay-outs both succeed and run short. Large and extreme
    // values and fully random noise words are mixed in.
    function automatic t_req random_word();
        t_req        w;
        int unsigned pick;
        int unsigned size_pick;
        w.req_type   = 1'($urandom);
        w.coin_index = INDEX_W'($urandom);
        w.coin_count = COUNT_W'($urandom);
        w.amount     = AMOUNT_W'($urandom);
        pick      = $urandom_range(99);
        size_pick = $urandom_range(99);
        if (pick < 28) begin
            w.req_type   = REQ_RESTOCK;
            w.coin_index = INDEX_W'($urandom_range(NUM_DENOMS - 1));
            if (size_pick < 70) begin
                w.coin_count = COUNT_W'($urandom_range(30));
            end else if (size_pick < 85) begin
                w.coin_count = COUNT_W'($urandom);
            end else if (size_pick < 95) begin
                w.coin_count = MAX_COUNT;
            end else begin
                w.coin_count = '0;
            end
        end else if (pick < 31) begin
            w.req_type   = REQ_RESTOCK;
            w.coin_index = BAD_COIN_INDEX;
        end else if (pick < 90) begin
            w.req_type = REQ_PAY;
            if (size_pick < 60) begin
                w.amount = AMOUNT_W'($urandom_range(400));
            end else if (size_pick < 80) begin
                w.amount = AMOUNT_W'($urandom_range(5000));
            end else if (size_pick < 90) begin
                w.amount = AMOUNT_W'($urandom);
            end else if (size_pick < 95) begin
                w.amount = MAX_AMOUNT;
            end else begin
                w.amount = '0;
            end
        end
        return w;
    endfunction

    function automatic void note_failure(input string what, input int want, input int got);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    // Holds a word on the inputs until the block takes it. The strobe and busy are read
    // just after the edge, before any register update lands, so they show the values
    // that the edge itself saw. start is left high so that back-to-back words never
    // lower and raise it in the same step.
    task automatic send_word(input t_req w, input logic pinned, input t_res res);
        start     <= 1'b1;
        i_req     <= w;
        pin_valid <= pinned;
        pin_res   <= res;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Monitor: checks each result word against the oldest expectation, then records
    // the expectation for any word taken at this edge. A result can never belong to a
    // word taken at the same edge, so the order of the two does not matter.
    always @(posedge i_clk) begin : monitor
        t_res want;
        t_res model;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    note_failure("unexpected result word, accepted", -1,
                                 int'(o_result.accepted));
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.accepted !== want.accepted) begin
                        note_failure("accepted", int'(want.accepted), int'(o_result.accepted));
                    end
                    if (o_result.remainder !== want.remainder) begin
                        note_failure("remainder", int'(want.remainder),
                                     int'(o_result.remainder));
                    end
                end
            end
            if (start && !busy) begin
                model = dispense_change(i_req);
                if (i_req.req_type == REQ_RESTOCK) begin
                    restock_words++;
                    if (!model.accepted) begin
                        bad_index++;
                    end
                end else begin
                    payout_words++;
                    if (model.accepted) begin
                        paid_exactly++;
                    end else begin
                        pay_stopped++;
                    end
                end
                expected_results.insert(expected_results.size(), pin_valid ? pin_res : model);
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int idle_pct [3];
        int phase;
        int n;
        idle_pct = '{26, 56, 0};
        for (n = 0; n < NUM_DENOMS; n++) begin
            shadow_stock[n] = '0;
        end

        // Directed script. Typed results cover the empty stock after reset, the extremes,
        // the refused index and every restock; the rest follow the shadow model.
        add_row(row(REQ_PAY, COIN_1, '0, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_PAY, COIN_1, '0, 20'd1, 1'b1, 1'b0, 20'd1));
        add_row(row(REQ_PAY, COIN_1, '0, MAX_AMOUNT, 1'b1, 1'b0, MAX_AMOUNT));
        add_row(row(REQ_RESTOCK, BAD_COIN_INDEX, MAX_COUNT, '0, 1'b1, 1'b0, '0));
        add_row(row(REQ_RESTOCK, COIN_1, MAX_COUNT, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_RESTOCK, COIN_2, 16'd4, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_RESTOCK, COIN_5, 16'd1, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_RESTOCK, COIN_10, 16'd2, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_RESTOCK, COIN_20, 16'd0, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_RESTOCK, COIN_50, 16'd3, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_RESTOCK, COIN_100, MAX_COUNT, '0, 1'b1, 1'b1, '0));
        // The largest amount is paid from the hundreds down to the fives.
        add_row(row(REQ_PAY, COIN_1, '0, MAX_AMOUNT, 1'b0, 1'b0, '0));
        // Index and count are ignored by a pay-out.
        add_row(row(REQ_PAY, BAD_COIN_INDEX, MAX_COUNT, 20'd3, 1'b0, 1'b0, '0));
        add_row(row(REQ_RESTOCK, COIN_100, '0, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_RESTOCK, COIN_2, '0, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_RESTOCK, COIN_1, '0, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_RESTOCK, COIN_20, 16'd3, '0, 1'b1, 1'b1, '0));
        // Greedy dead end: a fifty leaves ten owed although three twenties would do.
        add_row(row(REQ_PAY, COIN_1, '0, 20'd60, 1'b0, 1'b0, '0));
        // The amount is ignored by a restock.
        add_row(row(REQ_RESTOCK, COIN_10, MAX_COUNT, MAX_AMOUNT, 1'b1, 1'b1, '0));
        add_row(row(REQ_PAY, COIN_1, '0, 20'd60, 1'b0, 1'b0, '0));
        add_row(row(REQ_PAY, BAD_COIN_INDEX, MAX_COUNT, '0, 1'b1, 1'b1, '0));
        add_row(row(REQ_PAY, COIN_1, '0, 20'd1, 1'b0, 1'b0, '0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].word_in, directed_rows[r].pinned, directed_rows[r].res);
        end

        // Random traffic in three phases: light sender idling, heavy idling, none.
        // Before the second and third phases the sender waits for the block to drain.
        for (phase = 0; phase < 3; phase++) begin
            if (phase != 0) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (expected_results.size() != 0) begin
                    @(posedge i_clk);
                end
            end
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                send_word(random_word(), 1'b0, '0);
                if ($urandom_range(99) < idle_pct[phase]) begin
                    start <= 1'b0;
                    repeat ($urandom_range(MAX_GAP, 1)) @(posedge i_clk);
                end
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d restock words (%0d with no such coin) and %0d pay-out words",
                 restock_words, bad_index, payout_words);
        $display("pay-outs paid exactly: %0d, stopped short: %0d, mismatches: %0d",
                 paid_exactly, pay_stopped, failures);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
